>>> sv/masked_byte_signature_scanner_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef MASKED_BYTE_SIGNATURE_SCANNER_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SCANNER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MBSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mbss_pkg.sv
// Types, constants and helpers for the masked byte signature scanner.
`default_nettype none

package mbss_pkg;

    localparam int ADDR_W     = 48;
    localparam int CFG_W      = 64;
    localparam int CFG_WORDS  = 3;
    localparam int PAT_SLOTS  = 24;
    localparam int SLOT_BITS  = CFG_WORDS * CFG_W;
    localparam int LEN_W      = 5;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 3'd0,
        CFG_PAT_MID  = 3'd1,
        CFG_PAT_HIGH = 3'd2,
        CFG_IGN_LOW  = 3'd3,
        CFG_IGN_MID  = 3'd4,
        CFG_IGN_HIGH = 3'd5,
        CFG_LENGTH   = 3'd6,
        CFG_LIMIT    = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              region_start;
    } t_in_item;

    typedef struct packed {
        logic              match_found;
        logic [ADDR_W-1:0] match_address;
        logic              limit_reached;
    } t_out_item;

    // Compare setup handed to one window cell.
    typedef struct packed {
        logic [7:0] pat;
        logic [7:0] ign;
        logic       used;
        logic       flush;
    } t_cell_cmp;

    // Byte idx of a packed pattern or mask bank; slots past the end read zero.
    function automatic logic [7:0] lane_byte(input logic [SLOT_BITS-1:0] bank,
                                             input logic [LEN_W-1:0]     idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < LEN_W'(PAT_SLOTS)) begin
            b = bank[{idx, 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/mbss_cell.sv
// One window cell: holds a past byte and checks it against its pattern slot.
`default_nettype none

module mbss_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_shift,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_valid,
    input  wire mbss_pkg::t_cell_cmp i_cmp,
    output logic [7:0]              o_byte,
    output logic                    o_valid,
    output logic                    o_ok
);

    logic [7:0] r_byte;
    logic       r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // Unused slot always passes; a used slot needs a held byte from this region.
    assign o_ok = !i_cmp.used ||
                  (r_valid && !i_cmp.flush && (((r_byte ^ i_cmp.pat) & ~i_cmp.ign) == 8'h00));

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> sv/masked_byte_signature_scanner.sv
// Top level of the masked byte signature scanner.
`default_nettype none

// Masked byte signature scanner. Bytes enter with their address and a
// region-start flag. A row of MAX_PATTERN_BYTES-1 cells holds the previous
// bytes of the current region, newest in cell 0, and shifts by one on every
// accepted item. Each cell compares its byte against the pattern slot that
// lines up with it for the configured length, under the per-bit ignore mask;
// the incoming byte is checked against the last pattern slot in the same
// cycle. A match needs length-1 held bytes of this region, so a region start
// empties the row before the test. One result item comes out per input item
// through a single output register; a new item is taken in the same cycle the
// held result is taken, so while results are taken the sustained rate is one
// item per cycle. Reported matches are counted (saturating at 0xffff); with a
// nonzero match limit, once the count reaches it further matches are dropped
// and limit_reached stays high. match_address is the address of the first
// matched byte, wrapping within ADDRESS_BITS; zero when there is no match.
// Configuration registers (index 0..7: pattern low/mid/high, ignore
// low/mid/high, length, limit) are written by a single-cycle write strobe;
// the user must write them only while the block is idle; this is not enforced.

`include "masked_byte_signature_scanner_macros.svh"

module masked_byte_signature_scanner #(
    parameter int MAX_PATTERN_BYTES = 24,
    parameter int ADDRESS_BITS      = 48
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire mbss_pkg::t_in_item                i_in_item,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output mbss_pkg::t_out_item                    o_out_item,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [mbss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mbss_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int NCELL = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
    localparam int LEN_W = mbss_pkg::LEN_W;
    localparam int CNT_W = mbss_pkg::COUNT_W;
    localparam int SUB_W = (ADDRESS_BITS < mbss_pkg::ADDR_W) ? ADDRESS_BITS
                                                              : mbss_pkg::ADDR_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    // configuration registers
    logic [mbss_pkg::CFG_WORDS-1:0][mbss_pkg::CFG_W-1:0] r_pat;
    logic [mbss_pkg::CFG_WORDS-1:0][mbss_pkg::CFG_W-1:0] r_ign;
    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_limit;

    // match count and output stage
    logic [CNT_W-1:0]  r_seen;
    logic [CNT_W-1:0]  n_seen;
    logic              r_out_valid;
    mbss_pkg::t_out_item r_out;
    mbss_pkg::t_out_item n_out;

    logic              w_accept;
    logic [LEN_W-1:0]  w_len;
    logic [7:0]        w_cur;
    logic              w_flush;
    logic              w_cur_ok;
    logic              w_window_hit;
    logic              w_limit_pre;
    logic              w_hit;
    logic [SUB_W-1:0]  w_first;

    logic [NCELL-1:0][7:0] w_cell_byte;
    logic [NCELL-1:0]      w_cell_valid;
    logic [NCELL-1:0]      w_cell_ok;

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat   <= '0;
            r_ign   <= '0;
            r_len   <= LEN_W'(1);
            r_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbss_pkg::CFG_PAT_LOW:  r_pat[0] <= i_cfg_wdata;
                mbss_pkg::CFG_PAT_MID:  r_pat[1] <= i_cfg_wdata;
                mbss_pkg::CFG_PAT_HIGH: r_pat[2] <= i_cfg_wdata;
                mbss_pkg::CFG_IGN_LOW:  r_ign[0] <= i_cfg_wdata;
                mbss_pkg::CFG_IGN_MID:  r_ign[1] <= i_cfg_wdata;
                mbss_pkg::CFG_IGN_HIGH: r_ign[2] <= i_cfg_wdata;
                mbss_pkg::CFG_LENGTH:   r_len    <= i_cfg_wdata[LEN_W-1:0];
                mbss_pkg::CFG_LIMIT:    r_limit  <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Length in use: zero acts as one, oversize clamps to the window size.
    always_comb begin
        w_len = r_len;
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end
    end

    // ---------------- handshake ----------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cur      = i_in_item.data_byte;
    assign w_flush    = i_in_item.region_start;

    // ---------------- cell row ----------------
    // Cell k holds the byte k+1 items back, matched to pattern slot len-2-k.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        mbss_pkg::t_cell_cmp w_cmp;
        logic [7:0]          w_in_byte;
        logic                w_in_valid;
        logic [LEN_W-1:0]    w_slot;

        assign w_slot     = w_len - LEN_W'(k) - LEN_W'(2);
        assign w_cmp.used = (LEN_W'(k) + LEN_W'(1)) < w_len;
        assign w_cmp.pat  = mbss_pkg::lane_byte(r_pat, w_slot);
        assign w_cmp.ign  = mbss_pkg::lane_byte(r_ign, w_slot);
        assign w_cmp.flush = w_flush;

        if (k == 0) begin : g_head
            assign w_in_byte  = w_cur;
            assign w_in_valid = 1'b1;
        end else begin : g_link
            // region start: only the current byte survives the shift
            assign w_in_byte  = w_cell_byte[k-1];
            assign w_in_valid = w_cell_valid[k-1] && !w_flush;
        end

        mbss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_byte  (w_in_byte),
            .i_valid (w_in_valid),
            .i_cmp   (w_cmp),
            .o_byte  (w_cell_byte[k]),
            .o_valid (w_cell_valid[k]),
            .o_ok    (w_cell_ok[k])
        );
    end

    // ---------------- match decision ----------------
    always_comb begin
        logic [LEN_W-1:0] last_slot;
        logic [7:0]       last_pat;
        logic [7:0]       last_ign;
        last_slot = w_len - LEN_W'(1);
        last_pat  = mbss_pkg::lane_byte(r_pat, last_slot);
        last_ign  = mbss_pkg::lane_byte(r_ign, last_slot);
        w_cur_ok  = ((w_cur ^ last_pat) & ~last_ign) == 8'h00;
    end

    assign w_window_hit = w_cur_ok && (&w_cell_ok);
    assign w_limit_pre  = (r_limit != '0) && (r_seen >= r_limit);
    assign w_hit        = w_window_hit && !w_limit_pre;

    // first matched byte, wrapping within the address width
    assign w_first = i_in_item.byte_address[SUB_W-1:0] - SUB_W'(w_len - LEN_W'(1));

    always_comb begin
        n_seen = r_seen;
        if (w_hit && (r_seen != mbss_pkg::COUNT_MAX)) begin
            n_seen = r_seen + CNT_W'(1);
        end
        n_out.match_found   = w_hit;
        n_out.match_address = w_hit ? mbss_pkg::ADDR_W'(w_first) : '0;
        n_out.limit_reached = (r_limit != '0) && (n_seen >= r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_seen      <= n_seen;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- checks ----------------
    `MBSS_ASSERT_IMPLY(a_match_counted, r_out_valid && r_out.match_found, r_seen != '0, "reported match not counted")
    `MBSS_ASSERT_NEXT(a_region_no_span, w_accept && w_flush && (w_len > LEN_W'(1)), !r_out.match_found, "match spans a region start")
    `MBSS_ASSERT_NEXT(a_count_monotonic, 1'b1, r_seen >= $past(r_seen) || !$past(i_rst_n), "match count went down")
    `MBSS_ASSERT_IMPLY(a_valid_prefix, 1'b1, (w_cell_valid & (w_cell_valid + NCELL'(1))) == '0, "window valid bits not contiguous")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for the masked byte signature scanner: directed list and random phases.
`timescale 1ns / 1ps

module tb;

    localparam logic [mbss_pkg::ADDR_W-1:0] ADDR_TOP = '1;
    localparam int HIST         = mbss_pkg::PAT_SLOTS - 1;  // previous bytes the window holds
    localparam int STALL_LIMIT  = 1000;           // cycles with no item moving
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 100;

    // One step of the directed list: a register write or an input item.
    typedef struct packed {
        logic                       is_write;
        mbss_pkg::t_cfg_reg         reg_sel;
        logic [mbss_pkg::CFG_W-1:0] value;
        mbss_pkg::t_in_item         item;
        logic                       typed;   // want holds a hand-written result
        mbss_pkg::t_out_item        want;
    } t_plan_row;

    // DUT-facing signals; the ones the bench drives are known from time zero
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    mbss_pkg::t_in_item         in_item   = '0;
    logic                       in_ready;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    mbss_pkg::t_out_item        out_item;
    logic                       cfg_we    = 1'b0;
    mbss_pkg::t_cfg_reg         cfg_index = mbss_pkg::CFG_PAT_LOW;
    logic [mbss_pkg::CFG_W-1:0] cfg_wdata = '0;

    // Hand-written result riding along with the item on the bus
    logic                       in_typed  = 1'b0;
    mbss_pkg::t_out_item        in_want   = '0;

    // Stimulus knobs
    logic                        idle_on   = 1'b1;
    logic [mbss_pkg::ADDR_W-1:0] next_addr = '0;

    // Scanner model: configuration copy plus window, fill level and hit count
    logic [mbss_pkg::SLOT_BITS-1:0] pat_bank  = '0;
    logic [mbss_pkg::SLOT_BITS-1:0] ign_bank  = '0;
    logic [mbss_pkg::LEN_W-1:0]     len_reg   = mbss_pkg::LEN_W'(1);
    logic [mbss_pkg::COUNT_W-1:0]   limit_reg = '0;
    logic [7:0]                     hist [HIST] = '{default: 8'h00};
    int                             hist_fill = 0;
    logic [mbss_pkg::COUNT_W-1:0]   hits_seen = '0;

    mbss_pkg::t_out_item  pending_results[$];
    t_plan_row            plan[$];
    int                   mismatches  = 0;
    int                   idle_cycles = 0;

    masked_byte_signature_scanner dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Length in use: zero acts as one, anything past the slot count is clipped.
    function automatic int eff_len();
        if (len_reg == '0) begin
            return 1;
        end
        if (len_reg > mbss_pkg::LEN_W'(mbss_pkg::PAT_SLOTS)) begin
            return mbss_pkg::PAT_SLOTS;
        end
        return int'(len_reg);
    endfunction

    // Advance the model by one byte and produce the result that byte causes.
    task automatic predict_scan(input mbss_pkg::t_in_item it, output mbss_pkg::t_out_item res);
        int         len;
        int         back;
        int         i;
        logic [7:0] b;
        logic       hit;
        len = eff_len();
        // region start empties the window before the current byte is tested
        if (it.region_start) begin
            foreach (hist[k]) begin
                hist[k] = 8'h00;
            end
            hist_fill = 0;
        end
        // pattern slot 0 lines up with the oldest byte, slot len-1 with this byte
        hit = (hist_fill + 1 >= len);
        for (i = 0; i < len; i++) begin
            back = len - 1 - i;
            b = (back == 0) ? it.data_byte : hist[back - 1];
            if (((b ^ pat_bank[i*8 +: 8]) & ~ign_bank[i*8 +: 8]) != 8'h00) begin
                hit = 1'b0;
            end
        end
        // once the nonzero limit is reached, hits are neither reported nor counted
        if (hit && limit_reg != '0 && hits_seen >= limit_reg) begin
            hit = 1'b0;
        end
        res = '0;
        if (hit) begin
            if (hits_seen != mbss_pkg::COUNT_MAX) begin
                hits_seen++;
            end
            res.match_found   = 1'b1;
            res.match_address = it.byte_address - mbss_pkg::ADDR_W'(len - 1);
        end
        for (i = HIST - 1; i > 0; i--) begin
            hist[i] = hist[i - 1];
        end
        hist[0] = it.data_byte;
        if (hist_fill < HIST) begin
            hist_fill++;
        end
        res.limit_reached = (limit_reg != '0) && (hits_seen >= limit_reg);
    endtask

    // Everything is sampled here, at the rising edge, before the DUT's own updates land.
    // Order matters: the result leaving belongs to an older item than the one entering.
    always @(posedge clk) begin : result_check
        mbss_pkg::t_out_item got;
        mbss_pkg::t_out_item want;
        mbss_pkg::t_out_item predicted;
        if (rst_n) begin
            idle_cycles++;
            if (cfg_we) begin
                idle_cycles = 0;
                case (cfg_index)
                    mbss_pkg::CFG_PAT_LOW:  pat_bank[0 +: mbss_pkg::CFG_W] = cfg_wdata;
                    mbss_pkg::CFG_PAT_MID:  pat_bank[mbss_pkg::CFG_W +: mbss_pkg::CFG_W] =
                        cfg_wdata;
                    mbss_pkg::CFG_PAT_HIGH: pat_bank[2*mbss_pkg::CFG_W +: mbss_pkg::CFG_W] =
                        cfg_wdata;
                    mbss_pkg::CFG_IGN_LOW:  ign_bank[0 +: mbss_pkg::CFG_W] = cfg_wdata;
                    mbss_pkg::CFG_IGN_MID:  ign_bank[mbss_pkg::CFG_W +: mbss_pkg::CFG_W] =
                        cfg_wdata;
                    mbss_pkg::CFG_IGN_HIGH: ign_bank[2*mbss_pkg::CFG_W +: mbss_pkg::CFG_W] =
                        cfg_wdata;
                    mbss_pkg::CFG_LENGTH:   len_reg   = cfg_wdata[mbss_pkg::LEN_W-1:0];
                    mbss_pkg::CFG_LIMIT:    limit_reg = cfg_wdata[mbss_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid === 1'b1 && out_ready) begin
                idle_cycles = 0;
                got = out_item;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result item found=%0b addr=%h limit=%0b",
                                 $realtime, got.match_found, got.match_address,
                                 got.limit_reached);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.match_found !== want.match_found ||
                        got.match_address !== want.match_address ||
                        got.limit_reached !== want.limit_reached) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch want found=%0b addr=%h limit=%0b",
                                     $realtime, want.match_found, want.match_address,
                                     want.limit_reached);
                            $display("%0t:           got found=%0b addr=%h limit=%0b",
                                     $realtime, got.match_found, got.match_address,
                                     got.limit_reached);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready === 1'b1) begin
                idle_cycles = 0;
                // model always steps; a hand-written result replaces its answer
                predict_scan(in_item, predicted);
                pending_results.insert(pending_results.size(),
                                       in_typed ? in_want : predicted);
            end
        end
    end

    // Result side: random stall before each item, none while idling is off.
    initial begin : result_sink
        int stall;
        @(negedge clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(rst_n && out_valid === 1'b1 && out_ready)) begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // Ends a hung run.
    initial begin : watchdog
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
        end
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void add_row(input t_plan_row row);
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_write(input mbss_pkg::t_cfg_reg r,
                                       input logic [mbss_pkg::CFG_W-1:0] v);
        t_plan_row row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_sel  = r;
        row.value    = v;
        add_row(row);
    endfunction

    function automatic void plan_item(input logic [7:0] d,
                                      input logic [mbss_pkg::ADDR_W-1:0] a,
                                      input logic rs, input logic typed,
                                      input logic found,
                                      input logic [mbss_pkg::ADDR_W-1:0] maddr,
                                      input logic lim);
        t_plan_row row;
        row = '0;
        row.item.data_byte     = d;
        row.item.byte_address  = a;
        row.item.region_start  = rs;
        row.typed              = typed;
        row.want.match_found   = found;
        row.want.match_address = maddr;
        row.want.limit_reached = lim;
        add_row(row);
    endfunction

    // All tasks below start and end on a falling edge.
    task automatic write_reg(input mbss_pkg::t_cfg_reg r, input logic [mbss_pkg::CFG_W-1:0] v);
        cfg_index <= r;
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Hold off new items until every result is back, then let the pipe settle.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic send_byte(input mbss_pkg::t_in_item it, input logic typed,
                             input mbss_pkg::t_out_item want);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_typed <= typed;
        in_want  <= want;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready === 1'b1)) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stream byte at a running address; region starts sometimes jump, often near the top.
    task automatic drive_byte(input logic [7:0] d, input logic rs);
        mbss_pkg::t_in_item it;
        if (rs && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) begin
                next_addr = ADDR_TOP - mbss_pkg::ADDR_W'($urandom_range(0, 30));
            end else begin
                next_addr = mbss_pkg::ADDR_W'({$urandom, $urandom});
            end
        end
        it.data_byte    = d;
        it.byte_address = next_addr;
        it.region_start = rs;
        send_byte(it, 1'b0, '0);
        next_addr = next_addr + 1'b1;
    endtask

    // Fresh random setting of all eight registers; force_len < 0 picks the length too.
    task automatic new_setting(input int force_len);
        int                         w;
        int                         b;
        int                         pick;
        logic [mbss_pkg::CFG_W-1:0] word;
        logic [mbss_pkg::LEN_W-1:0] len_val;
        logic [15:0]                lim;
        settle_idle();
        for (w = 0; w < mbss_pkg::CFG_WORDS; w++) begin
            pick = $urandom_range(0, 7);
            word = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
            write_reg(mbss_pkg::t_cfg_reg'(int'(mbss_pkg::CFG_PAT_LOW) + w), word);
            // mostly exact bytes, some wildcards, some partial masks
            for (b = 0; b < 8; b++) begin
                pick = $urandom_range(0, 9);
                word[b*8 +: 8] = (pick < 6) ? 8'h00 : (pick < 8) ? 8'hff : 8'($urandom);
            end
            write_reg(mbss_pkg::t_cfg_reg'(int'(mbss_pkg::CFG_IGN_LOW) + w), word);
        end
        if (force_len >= 0) begin
            len_val = mbss_pkg::LEN_W'(force_len);
        end else begin
            case ($urandom_range(0, 9))
                0:       len_val = mbss_pkg::LEN_W'(mbss_pkg::PAT_SLOTS);
                1:       len_val = $urandom_range(0, 1) ?
                                   mbss_pkg::LEN_W'($urandom_range(25, 31)) : '0;
                2:       len_val = mbss_pkg::LEN_W'($urandom_range(9, 23));
                default: len_val = mbss_pkg::LEN_W'($urandom_range(1, 6));
            endcase
        end
        // upper bits of the write data are noise the register must drop
        write_reg(mbss_pkg::CFG_LENGTH, {$urandom, 27'($urandom), len_val});
        case ($urandom_range(0, 6))
            3:       lim = hits_seen + 16'($urandom_range(1, 6));
            4:       lim = 16'($urandom_range(1, 65535));
            5:       lim = (hits_seen == '0) ? 16'd1 : 16'($urandom_range(1, hits_seen));
            6:       lim = mbss_pkg::COUNT_MAX;
            default: lim = '0;
        endcase
        write_reg(mbss_pkg::CFG_LIMIT, {$urandom, 16'($urandom), lim});
    endtask

    // Mostly runs shaped to the pattern (some with one byte spoiled), the rest noise.
    task automatic run_phase(input int n_items);
        int         len;
        int         sent;
        int         pause_at;
        int         flip;
        int         k;
        int         n;
        logic       rs;
        logic [7:0] d;
        len      = eff_len();
        pause_at = $urandom_range(1, n_items);
        sent     = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                flip = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len - 1)) : -1;
                rs   = $urandom_range(0, 1);
                for (k = 0; k < len; k++) begin
                    d = pat_bank[k*8 +: 8] ^ (8'($urandom) & ign_bank[k*8 +: 8]);
                    if (k == flip) begin
                        d = d ^ ~ign_bank[k*8 +: 8];
                    end
                    drive_byte(d, rs && k == 0);
                    sent++;
                    if (sent == pause_at) begin
                        settle_idle();
                    end
                end
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    drive_byte(8'($urandom), $urandom_range(0, 7) == 0);
                    sent++;
                    if (sent == pause_at) begin
                        settle_idle();
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        t_plan_row row;
        logic      last_item;
        int        p;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: one zero byte, exact, no limit
        plan_item(8'h00, '0, 1'b1, 1'b1, 1'b1, '0, 1'b0);
        plan_item(8'hff, ADDR_TOP, 1'b0, 1'b1, 1'b0, '0, 1'b0);
        plan_item(8'h00, ADDR_TOP, 1'b0, 1'b1, 1'b1, ADDR_TOP, 1'b0);
        plan_item(8'h80, 48'd1, 1'b0, 1'b1, 1'b0, '0, 1'b0);
        // Three-byte pattern 11 ?? 33, middle byte a wildcard; unused banks at extremes
        plan_write(mbss_pkg::CFG_PAT_LOW, 64'h0000_0000_0033_a511);
        plan_write(mbss_pkg::CFG_PAT_MID, '1);
        plan_write(mbss_pkg::CFG_PAT_HIGH, '0);
        plan_write(mbss_pkg::CFG_IGN_LOW, 64'h0000_0000_0000_ff00);
        plan_write(mbss_pkg::CFG_IGN_MID, '1);
        plan_write(mbss_pkg::CFG_IGN_HIGH, '0);
        plan_write(mbss_pkg::CFG_LENGTH, 64'd3);
        plan_write(mbss_pkg::CFG_LIMIT, '0);
        // match whose first byte sits just below the top, address wraps
        plan_item(8'h11, ADDR_TOP - 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0);
        plan_item(8'h5c, ADDR_TOP, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        plan_item(8'h33, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        // same bytes, but a region start cuts the window short
        plan_item(8'h11, 48'd1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        plan_item(8'h00, 48'd2, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        plan_item(8'h33, 48'd3, 1'b1, 1'b0, 1'b0, '0, 1'b0);
        plan_item(8'h33, 48'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        // length zero behaves as one
        plan_write(mbss_pkg::CFG_LENGTH, '0);
        plan_write(mbss_pkg::CFG_PAT_LOW, 64'h5a);
        plan_item(8'h5a, 48'h1234, 1'b0, 1'b1, 1'b1, 48'h1234, 1'b0);
        plan_item(8'h5b, 48'h1235, 1'b0, 1'b1, 1'b0, '0, 1'b0);
        // limit lowered below the count: already reached
        plan_write(mbss_pkg::CFG_LIMIT, 64'd2);
        plan_item(8'h5a, 48'd7, 1'b0, 1'b1, 1'b0, '0, 1'b1);
        // limit met by this very hit, then the next one is dropped
        plan_write(mbss_pkg::CFG_LIMIT, 64'd5);
        plan_item(8'h5a, 48'd9, 1'b0, 1'b1, 1'b1, 48'd9, 1'b1);
        plan_item(8'h5a, 48'd10, 1'b0, 1'b1, 1'b0, '0, 1'b1);
        plan_write(mbss_pkg::CFG_LIMIT, '0);
        plan_item(8'h5a, 48'd11, 1'b0, 1'b1, 1'b1, 48'd11, 1'b0);

        last_item = 1'b0;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                if (last_item) begin
                    settle_idle();
                end
                write_reg(row.reg_sel, row.value);
            end else begin
                send_byte(row.item, row.typed, row.want);
            end
            last_item = !row.is_write;
        end

        // Random phases; first three pin the length at full, oversized and zero.
        // Every fourth phase runs with no idling on either side.
        for (p = 0; p < PHASES; p++) begin
            idle_on = (p % 4 != 3);
            new_setting((p == 0) ? mbss_pkg::PAT_SLOTS : (p == 1) ? 31 : (p == 2) ? 0 : -1);
            run_phase(PHASE_ITEMS);
        end

        settle_idle();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
